FILE: rtl/hsvsa_pkg.sv
// Package for the HSV saturation adjust block: pixel words, queue item and constants.
// Used by every module under rtl.
package hsvsa_pkg;

  localparam int CHAN_W      = 8;
  localparam int GAIN_W      = 16;
  localparam int COLOR_BITS  = 8;
  localparam int QUO_W       = 17;
  localparam logic [15:0] GAIN_RESET = 16'd256;

  typedef enum logic [2:0] {
    SEC_0, SEC_1, SEC_2, SEC_3, SEC_4, SEC_5
  } sector_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
  } pixel_out_t;

  // Classified pixel handed from the front to the back
  typedef struct packed {
    logic              black;
    sector_e           sector;
    logic [CHAN_W-1:0] v;
    logic [CHAN_W-1:0] delta;
    logic [CHAN_W-1:0] rem;
  } work_t;

endpackage

FILE: rtl/hsvsa_front.sv
// Front stage: finds max, delta, hue sector and sector remainder of a pixel.
// Depends on hsvsa_pkg.
module hsvsa_front #(
  parameter int COLOR_BITS = hsvsa_pkg::COLOR_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hsvsa_pkg::pixel_in_t in_pixel_i,
  output logic                 f_valid_o,
  input  logic                 f_ready_i,
  output hsvsa_pkg::work_t     f_item_o
);

  localparam int EW = (COLOR_BITS < hsvsa_pkg::CHAN_W) ? COLOR_BITS : hsvsa_pkg::CHAN_W;
  localparam int PW = EW + 3;

  logic [EW-1:0] r, g, b, mx, mn, dl;
  logic [PW-1:0] d1, d2, d3, d4, d5, d6, pos, base, rem_w;
  hsvsa_pkg::sector_e sec;
  hsvsa_pkg::work_t item_d, item_q;
  logic valid_q;

  // Classify the incoming pixel
  always_comb begin
    r  = in_pixel_i.red[EW-1:0];
    g  = in_pixel_i.green[EW-1:0];
    b  = in_pixel_i.blue[EW-1:0];
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl = mx - mn;
    d1 = PW'(dl);
    d2 = d1 << 1;
    d3 = d2 + d1;
    d4 = d1 << 2;
    d5 = d4 + d1;
    d6 = d3 << 1;
    if (r == mx) begin
      pos = PW'(g) - PW'(b);
      if (g < b) pos = pos + d6;
    end else if (g == mx) begin
      pos = d2 + PW'(b) - PW'(r);
    end else begin
      pos = d4 + PW'(r) - PW'(g);
    end
    if (pos >= d5) begin
      sec = hsvsa_pkg::SEC_5; base = d5;
    end else if (pos >= d4) begin
      sec = hsvsa_pkg::SEC_4; base = d4;
    end else if (pos >= d3) begin
      sec = hsvsa_pkg::SEC_3; base = d3;
    end else if (pos >= d2) begin
      sec = hsvsa_pkg::SEC_2; base = d2;
    end else if (pos >= d1) begin
      sec = hsvsa_pkg::SEC_1; base = d1;
    end else begin
      sec = hsvsa_pkg::SEC_0; base = '0;
    end
    rem_w         = pos - base;
    item_d.black  = (mx == '0);
    item_d.sector = sec;
    item_d.v      = hsvsa_pkg::CHAN_W'(mx);
    item_d.delta  = hsvsa_pkg::CHAN_W'(dl);
    item_d.rem    = hsvsa_pkg::CHAN_W'(rem_w[EW-1:0]);
  end

  assign in_ready_o = !valid_q || f_ready_i;

  // Hold the classified word until the queue takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign f_valid_o = valid_q;
  assign f_item_o  = item_q;

endmodule

FILE: rtl/hsvsa_queue.sv
// Two-entry queue between front and back stages.
// Depends on hsvsa_pkg.
module hsvsa_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  hsvsa_pkg::work_t push_item_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output hsvsa_pkg::work_t pop_item_o
);

  hsvsa_pkg::work_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: rtl/hsvsa_divider.sv
// Pipelined restoring divider: floor(num * 65536 / den) for num <= den, one bit per stage.
// Depends on hsvsa_pkg.
module hsvsa_divider #(
  parameter int EW = hsvsa_pkg::CHAN_W
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [EW-1:0]                num_i,
  input  logic [EW-1:0]                den_i,
  output logic [hsvsa_pkg::QUO_W-1:0]  quo_o
);

  localparam int NS = hsvsa_pkg::QUO_W;

  logic [EW-1:0] rem_q [NS];
  logic [EW-1:0] den_q [NS];
  logic [NS-1:0] quo_q [NS];

  // First stage: integer bit of the quotient
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0] <= den_i;
      if (num_i >= den_i) begin
        rem_q[0] <= num_i - den_i;
        quo_q[0] <= NS'(1);
      end else begin
        rem_q[0] <= num_i;
        quo_q[0] <= '0;
      end
    end
  end

  // Remaining stages: one fraction bit each
  for (genvar k = 1; k < NS; k++) begin : g_stage
    logic [EW:0] tmp;
    assign tmp = {rem_q[k-1], 1'b0};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k] <= den_q[k-1];
        if (tmp >= {1'b0, den_q[k-1]}) begin
          rem_q[k] <= EW'(tmp - {1'b0, den_q[k-1]});
          quo_q[k] <= {quo_q[k-1][NS-2:0], 1'b1};
        end else begin
          rem_q[k] <= tmp[EW-1:0];
          quo_q[k] <= {quo_q[k-1][NS-2:0], 1'b0};
        end
      end
    end
  end

  assign quo_o = quo_q[NS-1];

endmodule

FILE: rtl/hsvsa_back.sv
// Back pipeline: saturation and hue fraction division, gain scaling, p/q/t and RGB rebuild.
// Depends on hsvsa_pkg and hsvsa_divider.
module hsvsa_back #(
  parameter int COLOR_BITS = hsvsa_pkg::COLOR_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_valid_i,
  output logic                             q_pop_o,
  input  hsvsa_pkg::work_t                 q_item_i,
  input  logic [hsvsa_pkg::GAIN_W-1:0]     gain_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output hsvsa_pkg::pixel_out_t            out_pixel_o
);

  localparam int EW = (COLOR_BITS < hsvsa_pkg::CHAN_W) ? COLOR_BITS : hsvsa_pkg::CHAN_W;
  localparam int NS = hsvsa_pkg::QUO_W;
  localparam logic [16:0] ONE = 17'h10000;

  logic adv;
  logic [NS-1:0] s_quo, f_quo;
  logic [NS-1:0] vld_q;
  hsvsa_pkg::work_t side_q [NS];
  hsvsa_pkg::work_t m1_side_q, m2_side_q, m3_side_q;
  logic m1_vld_q, m2_vld_q, m3_vld_q, out_vld_q;
  logic [32:0] raw_q;
  logic [15:0] f1_q;
  logic [24:0] raw_sh;
  logic [16:0] ss_d, ss_q, fa, fb, fc;
  logic [32:0] ssf_q;
  logic [33:0] ssg_q;
  logic [EW-1:0] v3;
  logic [EW+16:0] pa, pb, pc;
  logic [EW-1:0] p_q, q_q, t_q;
  logic grey_q;
  logic [EW-1:0] v_o, ro, go, bo;
  hsvsa_pkg::pixel_out_t out_q;

  assign adv     = !out_vld_q || out_ready_i;
  assign q_pop_o = adv;

  hsvsa_divider #(.EW(EW)) u_sat_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (q_item_i.delta[EW-1:0]),
    .den_i (q_item_i.v[EW-1:0]),
    .quo_o (s_quo)
  );

  hsvsa_divider #(.EW(EW)) u_hue_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (q_item_i.rem[EW-1:0]),
    .den_i (q_item_i.delta[EW-1:0]),
    .quo_o (f_quo)
  );

  // Advance valid bits through every stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      m1_vld_q  <= 1'b0;
      m2_vld_q  <= 1'b0;
      m3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[NS-2:0], q_valid_i};
      m1_vld_q  <= vld_q[NS-1];
      m2_vld_q  <= m1_vld_q;
      m3_vld_q  <= m2_vld_q;
      out_vld_q <= m3_vld_q;
    end
  end

  // Carry the classified word alongside the dividers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= q_item_i;
      for (int k = 1; k < NS; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Clamp the scaled saturation to one and form the p/q/t products
  always_comb begin
    raw_sh = raw_q[32:8];
    ss_d   = (raw_sh > 25'(ONE)) ? ONE : raw_sh[16:0];
    fa     = ONE - ss_q;
    fb     = ONE - ssf_q[32:16];
    fc     = 17'(18'(ONE) - ssg_q[33:16]);
    v3     = m2_side_q.v[EW-1:0];
    pa     = {{17{1'b0}}, v3} * {{EW{1'b0}}, fa};
    pb     = {{17{1'b0}}, v3} * {{EW{1'b0}}, fb};
    pc     = {{17{1'b0}}, v3} * {{EW{1'b0}}, fc};
  end

  // Scale, form products, then p/q/t
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_side_q <= side_q[NS-1];
      raw_q     <= s_quo * gain_i;
      f1_q      <= f_quo[15:0];
      m2_side_q <= m1_side_q;
      ss_q      <= ss_d;
      ssf_q     <= ss_d * f1_q;
      ssg_q     <= ss_d * (ONE - {1'b0, f1_q});
      m3_side_q <= m2_side_q;
      grey_q    <= (ss_q == '0);
      p_q       <= pa[EW+15:16];
      q_q       <= pb[EW+15:16];
      t_q       <= pc[EW+15:16];
    end
  end

  // Rebuild RGB from the sector
  always_comb begin
    v_o = m3_side_q.v[EW-1:0];
    case (m3_side_q.sector)
      hsvsa_pkg::SEC_0: begin ro = v_o; go = t_q; bo = p_q; end
      hsvsa_pkg::SEC_1: begin ro = q_q; go = v_o; bo = p_q; end
      hsvsa_pkg::SEC_2: begin ro = p_q; go = v_o; bo = t_q; end
      hsvsa_pkg::SEC_3: begin ro = p_q; go = q_q; bo = v_o; end
      hsvsa_pkg::SEC_4: begin ro = t_q; go = p_q; bo = v_o; end
      default:          begin ro = v_o; go = p_q; bo = q_q; end
    endcase
    if (m3_side_q.black) begin
      ro = '0; go = '0; bo = '0;
    end else if (grey_q) begin
      ro = v_o; go = v_o; bo = v_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.red_out   <= hsvsa_pkg::CHAN_W'(ro);
      out_q.green_out <= hsvsa_pkg::CHAN_W'(go);
      out_q.blue_out  <= hsvsa_pkg::CHAN_W'(bo);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_pixel_o = out_q;

endmodule

FILE: rtl/hsv_saturation_adjust.sv
// HSV saturation adjust top level: gain register, front, queue and back pipeline.
// Depends on hsvsa_pkg, hsvsa_front, hsvsa_queue, hsvsa_back.
//
// Takes one RGB pixel per clock while in_ready_o is high and returns it with its
// HSV saturation scaled by the Q8.8 gain (256 = unchanged, result clamped to full
// saturation). Results leave in input order; the depth is set by the two 17-stage
// pipelined dividers (saturation and hue fraction) that work one quotient bit per
// stage. A two-entry queue sits between the classify stage and the arithmetic
// pipeline, and the whole back pipeline holds while the output word waits. Write
// the gain only while no pixels are in flight.
module hsv_saturation_adjust #(
  parameter int COLOR_BITS = hsvsa_pkg::COLOR_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hsvsa_pkg::GAIN_W-1:0] cfg_gain_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  hsvsa_pkg::pixel_in_t         in_pixel_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output hsvsa_pkg::pixel_out_t        out_pixel_o
);

  logic [hsvsa_pkg::GAIN_W-1:0] gain_q;
  logic f_valid, f_ready, q_valid, q_pop;
  hsvsa_pkg::work_t f_item, q_item;

  assign cfg_ready_o = 1'b1;

  // Hold the gain register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= hsvsa_pkg::GAIN_RESET;
    end else if (cfg_valid_i) begin
      gain_q <= cfg_gain_i;
    end
  end

  hsvsa_front #(.COLOR_BITS(COLOR_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_pixel_i (in_pixel_i),
    .f_valid_o  (f_valid),
    .f_ready_i  (f_ready),
    .f_item_o   (f_item)
  );

  hsvsa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_item_o   (q_item)
  );

  hsvsa_back #(.COLOR_BITS(COLOR_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .gain_i      (gain_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_pixel_o (out_pixel_o)
  );

endmodule

FILE: tb/hsv_saturation_adjust_chk.sv
// Checker for the HSV saturation adjust block: watches the pixel channels,
// predicts each output pixel from the gain and the input, and counts mismatches.
// Depends on hsvsa_pkg.
module hsv_saturation_adjust_chk (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [15:0]           cfg_gain_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  hsvsa_pkg::pixel_in_t  in_pixel_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  hsvsa_pkg::pixel_out_t out_pixel_i,
  output int                    fail_cnt_o,
  output int                    pending_o,
  output int                    checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import hsvsa_pkg::*;

  logic [15:0] gain_q;
  pixel_out_t  expected_pixels[$];

  // Scale v by a Q1.16 factor, truncating
  function automatic logic [63:0] scale_val(logic [63:0] v, logic [63:0] factor);
    return (v * factor) >> 16;
  endfunction

  // Rebuild the pixel with scaled saturation
  function automatic pixel_out_t adjust_pixel(pixel_in_t px, logic [15:0] g);
    logic [63:0] r, gr, b, mx, mn, delta, s, ss, upos, f, p, q, t;
    logic [63:0] sector;
    longint pos;
    pixel_out_t res;
    r = 64'(px.red); gr = 64'(px.green); b = 64'(px.blue);
    mx = r; mn = r;
    if (gr > mx) mx = gr;
    if (b > mx) mx = b;
    if (gr < mn) mn = gr;
    if (b < mn) mn = b;
    res = '0;
    if (mx == 0) return res;
    delta = mx - mn;
    s = (delta << 16) / mx;
    ss = (s * g) >> 8;
    if (ss > 65536) ss = 65536;
    if (ss == 0 || delta == 0) begin
      res.red_out = mx[7:0]; res.green_out = mx[7:0]; res.blue_out = mx[7:0];
      return res;
    end
    if (r == mx) pos = longint'(gr) - longint'(b);
    else if (gr == mx) pos = 2 * longint'(delta) + longint'(b) - longint'(r);
    else pos = 4 * longint'(delta) + longint'(r) - longint'(gr);
    if (pos < 0) pos += 6 * longint'(delta);
    upos = pos;
    sector = upos / delta;
    f = ((upos % delta) << 16) / delta;
    p = scale_val(mx, 65536 - ss);
    q = scale_val(mx, 65536 - ((ss * f) >> 16));
    t = scale_val(mx, 65536 - ((ss * (65536 - f)) >> 16));
    case (sector)
      0: res = '{mx[7:0], t[7:0], p[7:0]};
      1: res = '{q[7:0], mx[7:0], p[7:0]};
      2: res = '{p[7:0], mx[7:0], t[7:0]};
      3: res = '{p[7:0], q[7:0], mx[7:0]};
      4: res = '{t[7:0], p[7:0], mx[7:0]};
      default: res = '{mx[7:0], p[7:0], q[7:0]};
    endcase
    return res;
  endfunction

  assign pending_o = expected_pixels.size();

  // Track the gain, queue predictions, compare output words
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_out_t exp_px;
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
      fail_cnt_o <= 0;
      checked_o <= 0;
      expected_pixels.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) gain_q <= cfg_gain_i;
      if (in_valid_i && in_ready_i) expected_pixels.push_back(adjust_pixel(in_pixel_i, gain_q));
      if (out_valid_i && out_ready_i) begin
        checked_o <= checked_o + 1;
        if (expected_pixels.size() == 0) begin
          $error("output word with no pixel pending: %h", out_pixel_i);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          exp_px = expected_pixels.pop_front();
          if (exp_px != out_pixel_i) fail_cnt_o <= fail_cnt_o + 1;
          if (exp_px.red_out != out_pixel_i.red_out)
            $error("red_out expected %0d actual %0d", exp_px.red_out, out_pixel_i.red_out);
          if (exp_px.green_out != out_pixel_i.green_out)
            $error("green_out expected %0d actual %0d", exp_px.green_out,
                   out_pixel_i.green_out);
          if (exp_px.blue_out != out_pixel_i.blue_out)
            $error("blue_out expected %0d actual %0d", exp_px.blue_out, out_pixel_i.blue_out);
        end
      end
    end
  end
endmodule

FILE: tb/hsv_saturation_adjust_tb.sv
// Testbench top for the HSV saturation adjust block: clock, reset, gain phases,
// pixel stimulus with random idling and the verdict. Depends on hsvsa_pkg,
// hsv_saturation_adjust and hsv_saturation_adjust_chk.
module hsv_saturation_adjust_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hsvsa_pkg::*;

  localparam int LATENCY = 40;
  localparam int LIMIT   = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_gain = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  pixel_in_t   in_pixel = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  pixel_out_t  out_pixel;
  int          fail_cnt, pending, checked;
  int          cycle_cnt = 0;
  logic        hold_off = 1'b0;
  logic        calm = 1'b0;
  int          sent = 0;

  hsv_saturation_adjust u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_gain_i(cfg_gain),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_pixel_i(in_pixel),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_pixel_o(out_pixel)
  );

  hsv_saturation_adjust_chk u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_gain_i(cfg_gain),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_pixel_i(in_pixel),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_pixel_i(out_pixel),
    .fail_cnt_o(fail_cnt), .pending_o(pending), .checked_o(checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stall bursts, a long hold-off on request, none when calm
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 18);
        repeat (n) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 30);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // Send one pixel word, with a random idle burst ahead
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 18);
      repeat (n) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_pixel <= '{r, g, b};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent++;
  endtask

  // Drain the pipeline, then write the gain
  task automatic write_gain(logic [15:0] g);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_gain <= g;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Random pixel: mostly full range, some grey, some near-grey, some dark
  task automatic random_pixels(int count);
    logic [7:0] r, g, b, base;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: begin
          base = 8'($urandom); r = base; g = base; b = base;
        end
        1: begin
          base = 8'($urandom_range(1, 254));
          r = base;
          g = base + 8'($urandom_range(0, 1));
          b = base - 8'($urandom_range(0, 1));
        end
        2: begin
          r = 8'($urandom_range(0, 3));
          g = 8'($urandom_range(0, 3));
          b = 8'($urandom_range(0, 3));
        end
        default: begin
          r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
        end
      endcase
      send_pixel(r, g, b);
    end
  endtask

  initial begin
    logic [15:0] gains[8];
    gains = '{16'd0, 16'd1, 16'd128, 16'd256, 16'd300, 16'd512, 16'd4096, 16'hFFFF};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: black, white, greys, primaries, ties, each hue sector
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd100, 8'd50);
    send_pixel(8'd100, 8'd200, 8'd50);
    send_pixel(8'd50, 8'd200, 8'd100);
    send_pixel(8'd50, 8'd100, 8'd200);
    send_pixel(8'd100, 8'd50, 8'd200);
    send_pixel(8'd200, 8'd50, 8'd100);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd170, 8'd85, 8'd170);
    write_gain(16'd0);
    send_pixel(8'd200, 8'd100, 8'd50);
    write_gain(16'hFFFF);
    send_pixel(8'd200, 8'd100, 8'd50);
    send_pixel(8'd254, 8'd253, 8'd1);

    // Long receiver hold-off so the block fills and stalls its input
    hold_off = 1'b1;
    random_pixels(60);

    // Random phases over several gains
    foreach (gains[i]) begin
      write_gain(gains[i]);
      random_pixels(200);
    end
    write_gain(16'($urandom));
    random_pixels(200);

    // Final stretch with no idling on either side
    calm = 1'b1;
    random_pixels(150);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);

    $display("covered %0d pixels over %0d gain settings incl. 0, 1.0 and max; %0d checked",
             sent, 12, checked);
    if (fail_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
